// ----- rtl/core/rtst_pkg.sv -----
// Shared types and constants of the ribbon trail tessellator.
`default_nettype none
package rtst_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned InDataW = 192;
  localparam int unsigned OutDataW = 120;
  localparam logic [15:0] AlongMax = 16'd64225;

  // One head/tail pair: entries 0..2 head x/y/z, entries 3..5 tail x/y/z.
  typedef logic [5:0][CoordW-1:0] pair_t;

  typedef struct packed {
    logic item_clr;
    logic hist_shift;
    logic kept_push;
    logic kept_shift;
    logic adiv_start;
    logic spl_start;
    logic cand_kept;
    logic cand_spl;
    logic pend_load;
    logic slot_inc;
    logic emit_tail;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic keep_bit;
    logic adiv_done;
    logic spl_done;
    logic cand_zero;
    logic pend_v;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/ribbon_trail_spline_tessellator.sv -----
// Top level of the ribbon trail tessellator.
//
// Slave stream: one request per rendered frame carrying the head/tail pair.
// The pair is shifted into a HISTORY_DEPTH history, filtered into a kept
// list, smoothed by uniform Catmull-Rom when four or more points survive,
// and emitted on the master stream as head then tail vertex per point.
// Points with all six coordinates zero emit nothing; tlast marks the final
// vertex of the frame. A frame can produce no vertices at all.
// The block works on one request at a time: s_axis_tready is high only
// while idle. Each request scans the history and runs the 17-step along
// divide; each smoothed point then takes three coefficient stages and a
// four-chunk reciprocal divide in six parallel lanes.
// A stall on m_axis_tready holds the current vertex and freezes the walk.
// Reset clears the history to zero and returns the controller to idle.
`default_nettype none
module ribbon_trail_spline_tessellator #(
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned DIVISIONS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // head_x, head_y, head_z, tail_x, tail_y, tail_z
  input  wire logic [rtst_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // pos_x, pos_y, pos_z, along_coord, slot, zero pad
  output logic [rtst_pkg::OutDataW-1:0]      m_axis_tdata,
  // is_tail
  output logic [0:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned HIW = $clog2(HISTORY_DEPTH);
  localparam int unsigned JW = $clog2(DIVISIONS + 1);
  localparam int unsigned NPW = $clog2(1 + HISTORY_DEPTH * (DIVISIONS + 1) + 1);

  rtst_pkg::cmd_t  cmd;
  rtst_pkg::sts_t  sts;
  logic [HIW-1:0]  scan_idx;
  logic [JW-1:0]   spl_j;
  logic [NPW-1:0]  np_m1;
  logic [rtst_pkg::OutDataW-1:0] dp_data;

  rtst_ctrl #(.HD(HISTORY_DEPTH), .DIV(DIVISIONS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .scan_idx_o (scan_idx),
    .spl_j_o    (spl_j),
    .np_m1_o    (np_m1)
  );

  rtst_dp #(.HD(HISTORY_DEPTH), .DIV(DIVISIONS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .scan_idx_i (scan_idx),
    .spl_j_i    (spl_j),
    .np_m1_i    (np_m1),
    .in_data_i  (s_axis_tdata),
    .sts_o      (sts),
    .out_data_o (dp_data)
  );

  // The low bit of the slot field is is_tail; copy it onto tuser as well.
  assign m_axis_tdata = {2'b00, dp_data[117:0]};
  assign m_axis_tuser = dp_data[112];
  assign m_axis_tlast = cmd.out_last;

endmodule
`default_nettype wire

// ----- rtl/core/rtst_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rtst_div #(
  parameter int unsigned NUM_W = 17,
  parameter int unsigned DEN_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o,
  output logic [DEN_W-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[NUM_W-2:0], ge};
      rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- rtl/core/rtst_dp.sv -----
// Datapath: history, kept list, spline lanes, along step and vertex output.
`default_nettype none
module rtst_dp #(
  parameter int unsigned HD = 8,
  parameter int unsigned DIV = 4,
  localparam int unsigned HIW = $clog2(HD),
  localparam int unsigned JW = $clog2(DIV + 1),
  localparam int unsigned NPW = $clog2(1 + HD * (DIV + 1) + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rtst_pkg::cmd_t                 cmd_i,
  input  wire logic [HIW-1:0]                 scan_idx_i,
  input  wire logic [JW-1:0]                  spl_j_i,
  input  wire logic [NPW-1:0]                 np_m1_i,
  input  wire logic [rtst_pkg::InDataW-1:0]   in_data_i,
  output rtst_pkg::sts_t                      sts_o,
  output logic [rtst_pkg::OutDataW-1:0]       out_data_o
);

  localparam int unsigned D3 = DIV * DIV * DIV;
  localparam int unsigned D2X = 2 * D3;
  localparam int unsigned OffSh = 43;
  localparam logic [52:0] Bias = 53'(D2X) << OffSh;
  localparam logic [51:0] QOff = 52'(1) << OffSh;
  localparam logic [51:0] QHi = QOff + 52'h7FFF_FFFF;
  localparam logic [51:0] QLo = QOff - 52'h8000_0000;
  // Divide by 2*DIV^3 in four 13-bit chunks, each by reciprocal multiply.
  localparam int unsigned ChunkW = 13;
  localparam int unsigned CdSteps = 4;
  localparam int unsigned CdShift = 29;
  localparam logic [28:0] Recip =
      29'(((64'd1 << CdShift) + 64'(D2X) - 64'd1) / 64'(D2X));

  rtst_pkg::pair_t hist_q [HD];
  rtst_pkg::pair_t kept_q [HD];
  rtst_pkg::pair_t cand_q;
  rtst_pkg::pair_t pend_q;
  rtst_pkg::pair_t spl_res;
  logic [HD-1:0]   keep;
  logic            pend_v_q;
  logic [15:0]     pend_along_q;
  logic [4:0]      pend_slot_q;
  logic [NPW-1:0]  slot_cnt_q;
  logic [17:0]     aq_q;
  logic [NPW-1:0]  ar_q;
  logic [NPW:0]    ar_sum;
  logic [16:0]     adiv_q;
  logic [NPW-1:0]  adiv_r;
  logic [7:0]      cf_a;
  logic [7:0]      cf_b;
  logic [7:0]      cf_c;
  logic            s1_v_q;
  logic            s2_v_q;
  logic            cd_busy_q;
  logic            cd_ph_q;
  logic            cd_done_q;
  logic [2:0]      cd_cnt_q;

  // Keep rule: newest entry always; older ones must move and have length.
  always_comb begin
    keep[0] = 1'b1;
    for (int i = 1; i < HD; i++) begin
      keep[i] = (hist_q[i][2:0] != hist_q[i-1][2:0]) &&
                (hist_q[i][2:0] != hist_q[i][5:3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HD; i++) hist_q[i] <= '0;
    end else if (cmd_i.hist_shift) begin
      for (int i = HD - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
      hist_q[0] <= rtst_pkg::pair_t'(in_data_i);
    end
  end

  // Push at the front while scanning oldest first; shift down to walk spans.
  always_ff @(posedge clk_i) begin
    if (cmd_i.kept_push) begin
      for (int i = HD - 1; i > 0; i--) kept_q[i] <= kept_q[i-1];
      kept_q[0] <= hist_q[scan_idx_i];
    end else if (cmd_i.kept_shift) begin
      for (int i = 0; i < HD - 1; i++) kept_q[i] <= kept_q[i+1];
    end
  end

  assign cf_a = 8'(int'(spl_j_i) * int'(spl_j_i) * int'(spl_j_i));
  assign cf_b = 8'(DIV * int'(spl_j_i) * int'(spl_j_i));
  assign cf_c = 8'(DIV * DIV * int'(spl_j_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.spl_start;
      s2_v_q <= s1_v_q;
    end
  end

  // Chunk sequencer shared by all lanes: phase 0 multiplies, phase 1 settles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_busy_q <= 1'b0;
      cd_ph_q   <= 1'b0;
      cd_done_q <= 1'b0;
      cd_cnt_q  <= '0;
    end else begin
      cd_done_q <= 1'b0;
      if (s2_v_q) begin
        cd_busy_q <= 1'b1;
        cd_ph_q   <= 1'b0;
        cd_cnt_q  <= 3'(CdSteps);
      end else if (cd_busy_q) begin
        cd_ph_q <= ~cd_ph_q;
        if (cd_ph_q) begin
          cd_cnt_q <= cd_cnt_q - 1'b1;
          if (cd_cnt_q == 3'd1) begin
            cd_busy_q <= 1'b0;
            cd_done_q <= 1'b1;
          end
        end
      end
    end
  end

  for (genvar c = 0; c < 6; c++) begin : g_lane
    logic signed [35:0] e0, e1, e2, e3;
    logic signed [35:0] a_q, b_q, c_q;
    logic signed [31:0] p1_q;
    logic signed [44:0] t1_q, t2_q, t3_q, t4_q;
    logic [7:0]         ca_q, cb_q, cc_q;
    logic [52:0]        nsum;
    logic [51:0]        num_q;
    logic [51:0]        quot_q;
    logic [51:0]        qdiff;
    logic [7:0]         rem_q;
    logic [20:0]        cd_x;
    logic [49:0]        cd_prod;
    logic [20:0]        x_q;
    logic [ChunkW-1:0]  qc_q;
    logic [20:0]        qc_den;

    assign e0 = 36'($signed(kept_q[0][c]));
    assign e1 = 36'($signed(kept_q[1][c]));
    assign e2 = 36'($signed(kept_q[2][c]));
    assign e3 = 36'($signed(kept_q[3][c]));

    // Next chunk: remainder so far joined with the top numerator bits.
    assign cd_x    = {rem_q, num_q[51 -: ChunkW]};
    assign cd_prod = 50'(cd_x) * 50'(Recip);
    assign qc_den  = 21'(qc_q) * 21'(D2X);

    always_ff @(posedge clk_i) begin
      if (cmd_i.spl_start) begin
        a_q  <= e3 - e0 + 36'sd3 * (e1 - e2);
        b_q  <= 36'sd2 * e0 - 36'sd5 * e1 + 36'sd4 * e2 - e3;
        c_q  <= e2 - e0;
        p1_q <= $signed(kept_q[1][c]);
        ca_q <= cf_a;
        cb_q <= cf_b;
        cc_q <= cf_c;
      end
      if (s1_v_q) begin
        t1_q <= p1_q * $signed({1'b0, 8'(D2X)});
        t2_q <= c_q * $signed({1'b0, cc_q});
        t3_q <= b_q * $signed({1'b0, cb_q});
        t4_q <= a_q * $signed({1'b0, ca_q});
      end
      if (s2_v_q) begin
        num_q <= nsum[51:0];
        rem_q <= '0;
      end else if (cd_busy_q) begin
        if (!cd_ph_q) begin
          x_q   <= cd_x;
          qc_q  <= cd_prod[CdShift +: ChunkW];
          num_q <= num_q << ChunkW;
        end else begin
          rem_q  <= 8'(x_q - qc_den);
          quot_q <= {quot_q[51-ChunkW:0], qc_q};
        end
      end
    end

    // Offset keeps the numerator positive so the floor is a plain divide.
    assign nsum = 53'(t1_q) + 53'(t2_q) + 53'(t3_q) + 53'(t4_q) + 53'(D3) + Bias;

    assign qdiff = quot_q - QOff;

    always_comb begin
      if (quot_q > QHi) begin
        spl_res[c] = 32'h7FFF_FFFF;
      end else if (quot_q < QLo) begin
        spl_res[c] = 32'h8000_0000;
      end else begin
        spl_res[c] = qdiff[31:0];
      end
    end
  end

  rtst_div #(.NUM_W(17), .DEN_W(NPW)) u_adiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.adiv_start),
    .num_i  (17'h1_0000),
    .den_i  (np_m1_i),
    .done_o (sts_o.adiv_done),
    .quot_o (adiv_q),
    .rem_o  (adiv_r)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cand_kept) begin
      cand_q <= kept_q[0];
    end else if (cmd_i.cand_spl) begin
      cand_q <= spl_res;
    end
  end

  assign ar_sum = (NPW+1)'(ar_q) + (NPW+1)'(adiv_r);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q   <= 1'b0;
      slot_cnt_q <= '0;
      aq_q       <= '0;
      ar_q       <= '0;
    end else if (cmd_i.item_clr) begin
      pend_v_q   <= 1'b0;
      slot_cnt_q <= '0;
      aq_q       <= '0;
      ar_q       <= '0;
    end else begin
      if (cmd_i.slot_inc) slot_cnt_q <= slot_cnt_q + 1'b1;
      if (cmd_i.pend_load) begin
        pend_v_q <= 1'b1;
        // Step along by 1/(n-1): add quotient, carry remainder overflow.
        if (ar_sum >= (NPW+1)'(np_m1_i)) begin
          ar_q <= NPW'(ar_sum - (NPW+1)'(np_m1_i));
          aq_q <= aq_q + 18'(adiv_q) + 18'd1;
        end else begin
          ar_q <= NPW'(ar_sum);
          aq_q <= aq_q + 18'(adiv_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_q       <= cand_q;
      pend_slot_q  <= 5'(slot_cnt_q);
      pend_along_q <= (aq_q > 18'(rtst_pkg::AlongMax)) ? rtst_pkg::AlongMax : aq_q[15:0];
    end
  end

  assign sts_o.keep_bit  = keep[scan_idx_i];
  assign sts_o.spl_done  = cd_done_q;
  assign sts_o.cand_zero = (cand_q == '0);
  assign sts_o.pend_v    = pend_v_q;

  assign out_data_o = cmd_i.emit_tail ?
      {2'b00, pend_slot_q, 1'b1, pend_along_q, pend_q[5], pend_q[4], pend_q[3]} :
      {2'b00, pend_slot_q, 1'b0, pend_along_q, pend_q[2], pend_q[1], pend_q[0]};

endmodule
`default_nettype wire

// ----- rtl/core/rtst_ctrl.sv -----
// Controller: sequences scan, along divide, spline points and vertex output.
`default_nettype none
module rtst_ctrl #(
  parameter int unsigned HD = 8,
  parameter int unsigned DIV = 4,
  localparam int unsigned HIW = $clog2(HD),
  localparam int unsigned JW = $clog2(DIV + 1),
  localparam int unsigned NPW = $clog2(1 + HD * (DIV + 1) + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire rtst_pkg::sts_t  sts_i,
  output rtst_pkg::cmd_t       cmd_o,
  output logic [HIW-1:0]       scan_idx_o,
  output logic [JW-1:0]        spl_j_o,
  output logic [NPW-1:0]       np_m1_o
);

  localparam int unsigned NKW = $clog2(HD + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_NP, S_DIVS, S_DIVW, S_PT, S_EH, S_ET, S_NEXT, S_SPW, S_FLUSH
  } state_e;

  state_e          state_q, state_d;
  logic [HIW-1:0]  i_q, i_d;
  logic [NKW-1:0]  nk_q, nk_d;
  logic [NPW-1:0]  np_q, np_d;
  logic [NKW-1:0]  rem_q, rem_d;
  logic [NKW-1:0]  span_q, span_d;
  logic [JW-1:0]   j_q, j_d;
  logic            mode_q, mode_d;
  logic            final_q, final_d;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    nk_d    = nk_q;
    np_d    = np_q;
    rem_d   = rem_q;
    span_d  = span_q;
    j_d     = j_q;
    mode_d  = mode_q;
    final_d = final_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.hist_shift = 1'b1;
          cmd_o.item_clr   = 1'b1;
          i_d     = HIW'(HD - 1);
          nk_d    = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.keep_bit) begin
          cmd_o.kept_push = 1'b1;
          nk_d = nk_q + 1'b1;
        end
        if (i_q == '0) begin
          state_d = S_NP;
        end else begin
          i_d = i_q - 1'b1;
        end
      end
      S_NP: begin
        if (int'(nk_q) >= 4) begin
          np_d = NPW'(1 + (int'(nk_q) - 3) * (DIV + 1));
        end else begin
          np_d = NPW'(nk_q);
        end
        state_d = S_DIVS;
      end
      S_DIVS: begin
        if (int'(np_q) < 2) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.adiv_start = 1'b1;
          state_d = S_DIVW;
        end
      end
      S_DIVW: begin
        if (sts_i.adiv_done) begin
          cmd_o.cand_kept = 1'b1;
          if (int'(nk_q) >= 4) begin
            mode_d = 1'b1;
            span_d = NKW'(int'(nk_q) - 3);
            j_d    = '0;
          end else begin
            mode_d = 1'b0;
            cmd_o.kept_shift = 1'b1;
            rem_d  = nk_q - 1'b1;
          end
          state_d = S_PT;
        end
      end
      S_PT: begin
        if (sts_i.cand_zero) begin
          cmd_o.slot_inc = 1'b1;
          state_d = S_NEXT;
        end else if (!sts_i.pend_v) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.slot_inc  = 1'b1;
          state_d = S_NEXT;
        end else begin
          final_d = 1'b0;
          state_d = S_EH;
        end
      end
      S_EH: begin
        if (out_ready_i) state_d = S_ET;
      end
      S_ET: begin
        cmd_o.emit_tail = 1'b1;
        cmd_o.out_last  = final_q;
        if (out_ready_i) begin
          if (final_q) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.pend_load = 1'b1;
            cmd_o.slot_inc  = 1'b1;
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (!mode_q) begin
          if (rem_q == '0) begin
            state_d = S_FLUSH;
          end else begin
            cmd_o.cand_kept  = 1'b1;
            cmd_o.kept_shift = 1'b1;
            rem_d   = rem_q - 1'b1;
            state_d = S_PT;
          end
        end else if (span_q == '0) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.spl_start = 1'b1;
          state_d = S_SPW;
        end
      end
      S_SPW: begin
        if (sts_i.spl_done) begin
          cmd_o.cand_spl = 1'b1;
          if (j_q == JW'(DIV)) begin
            j_d    = '0;
            span_d = span_q - 1'b1;
            cmd_o.kept_shift = 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
          state_d = S_PT;
        end
      end
      S_FLUSH: begin
        if (sts_i.pend_v) begin
          final_d = 1'b1;
          state_d = S_EH;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      nk_q    <= '0;
      np_q    <= '0;
      rem_q   <= '0;
      span_q  <= '0;
      j_q     <= '0;
      mode_q  <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      nk_q    <= nk_d;
      np_q    <= np_d;
      rem_q   <= rem_d;
      span_q  <= span_d;
      j_q     <= j_d;
      mode_q  <= mode_d;
      final_q <= final_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EH) || (state_q == S_ET);
  assign scan_idx_o  = i_q;
  assign spl_j_o     = j_q;
  assign np_m1_o     = np_q - 1'b1;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("request accepted while vertices pending");
  a_last_on_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cmd_o.out_last) |-> cmd_o.emit_tail) else $error("last on head vertex");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && cmd_o.out_last) |=> in_ready_o)
    else $error("not idle after final vertex");
  a_no_zero_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pend_load |-> !sts_i.cand_zero) else $error("zero point queued for output");

endmodule
`default_nettype wire
